>>> rtl/core/rmq_pkg.sv
// ---------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Widths, the matrix word layout and the sideband that travels with each word.
// ---------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int NRM_W         = 30;   // normalised magnitudes lie below 2^30
    localparam int NRM_TOP       = 29;   // target leading one position
    localparam int SQ_W          = 62;   // sum of four squares of NRM_W bits
    localparam int ROOT_W        = 31;   // floor square root of SQ_W bits
    localparam int POS_W         = 6;    // leading one position

    typedef logic signed [IN_W-1:0] entry_t;

    typedef struct packed {
        entry_t zz;
        entry_t zy;
        entry_t zx;
        entry_t yz;
        entry_t yy;
        entry_t yx;
        entry_t xz;
        entry_t xy;
        entry_t xx;
    } mat_t;

    typedef struct packed {
        logic [3:0] neg;
        logic       invalid;
    } side_t;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

endpackage

>>> rtl/core/rmq_front.sv
// ---------------------------------------------------------------------------
// rmq_front: branch selection and component forming
// Two stages: radicands, sums and branch decision, then selection and magnitude.
// ---------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int RAD_W     = 20
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  mat_t                        mat,
    output logic                        out_valid,
    output logic [3:0][RAD_W-1:0]       mag,
    output side_t                       side
);

    localparam logic signed [RAD_W-1:0] ONE = {{(RAD_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [RAD_W-1:0] xx, yy, zz;
    logic signed [RAD_W-1:0] rad_next [4];
    logic signed [RAD_W-1:0] rad_reg  [4];
    logic signed [RAD_W-1:0] off_next [6];
    logic signed [RAD_W-1:0] off_reg  [6];
    branch_t                 br_next, br_reg;
    logic                    v1_reg;

    logic signed [RAD_W-1:0] r_sel;
    logic signed [RAD_W-1:0] c_sel [4];
    logic [3:0][RAD_W-1:0]   mag_next, mag_reg;
    side_t                   side_next, side_reg;
    logic                    v2_reg;

    assign xx = RAD_W'(mat.xx);
    assign yy = RAD_W'(mat.yy);
    assign zz = RAD_W'(mat.zz);

    always_comb
    begin
        rad_next[0] = ONE + xx + yy + zz;
        rad_next[1] = ONE + xx - yy - zz;
        rad_next[2] = ONE + yy - xx - zz;
        rad_next[3] = ONE + zz - xx - yy;
        // Differences feed every branch, sums only the diagonal branches.
        off_next[0] = RAD_W'(mat.zy) - RAD_W'(mat.yz);
        off_next[1] = RAD_W'(mat.xz) - RAD_W'(mat.zx);
        off_next[2] = RAD_W'(mat.yx) - RAD_W'(mat.xy);
        off_next[3] = RAD_W'(mat.xy) + RAD_W'(mat.yx);
        off_next[4] = RAD_W'(mat.xz) + RAD_W'(mat.zx);
        off_next[5] = RAD_W'(mat.yz) + RAD_W'(mat.zy);
        if ((xx + yy + zz) > 0)
            br_next = BR_TRACE;
        else if (xx > yy && xx > zz)
            br_next = BR_X;
        else if (yy > zz)
            br_next = BR_Y;
        else
            br_next = BR_Z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            off_reg  <= off_next;
            br_reg   <= br_next;
            mag_reg  <= mag_next;
            side_reg <= side_next;
        end
    end

    always_comb
    begin
        case (br_reg)
            BR_TRACE:
            begin
                r_sel = rad_reg[0];
                c_sel[0] = rad_reg[0]; c_sel[1] = off_reg[0];
                c_sel[2] = off_reg[1]; c_sel[3] = off_reg[2];
            end
            BR_X:
            begin
                r_sel = rad_reg[1];
                c_sel[0] = off_reg[0]; c_sel[1] = rad_reg[1];
                c_sel[2] = off_reg[3]; c_sel[3] = off_reg[4];
            end
            BR_Y:
            begin
                r_sel = rad_reg[2];
                c_sel[0] = off_reg[1]; c_sel[1] = off_reg[3];
                c_sel[2] = rad_reg[2]; c_sel[3] = off_reg[5];
            end
            default:
            begin
                r_sel = rad_reg[3];
                c_sel[0] = off_reg[2]; c_sel[1] = off_reg[4];
                c_sel[2] = off_reg[5]; c_sel[3] = rad_reg[3];
            end
        endcase
        side_next.invalid = (r_sel <= 0);
        for (int i = 0; i < 4; i++)
        begin
            side_next.neg[i] = c_sel[i][RAD_W-1];
            mag_next[i]      = c_sel[i][RAD_W-1] ? -c_sel[i] : c_sel[i];
        end
    end

    assign out_valid = v2_reg;
    assign mag       = mag_reg;
    assign side      = side_reg;

endmodule

>>> rtl/core/rmq_norm.sv
// ---------------------------------------------------------------------------
// rmq_norm: block normalisation and sum of squares
// Maximum, leading one search, common shift, squares and their sum.
// ---------------------------------------------------------------------------
module rmq_norm
    import rmq_pkg::*;
#(
    parameter int MAG_W = 20
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [3:0][MAG_W-1:0]       mag,
    input  side_t                       side_in,
    output logic                        out_valid,
    output logic [SQ_W-1:0]             nsum,
    output logic [3:0][NRM_W-1:0]       nmag,
    output side_t                       side_out
);

    logic [4:0]               v_reg;
    side_t                    side_reg [5];
    logic [MAG_W-1:0]         m01, m23, mx_next, mx_reg;
    logic [3:0][MAG_W-1:0]    mag3_reg, mag4_reg;
    logic [POS_W-1:0]         pos_next, pos_reg;
    logic [3:0][NRM_W-1:0]    nm_next, nm5_reg, nm6_reg, nm7_reg;
    logic [63:0]              wide;
    logic [POS_W-1:0]         sh;
    logic [2*NRM_W-1:0]       sq_reg [4];
    logic [SQ_W-1:0]          sum_reg;

    assign m01     = (mag[0] > mag[1]) ? mag[0] : mag[1];
    assign m23     = (mag[2] > mag[3]) ? mag[2] : mag[3];
    assign mx_next = (m01 > m23) ? m01 : m23;

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < MAG_W; i++)
            if (mx_reg[i])
                pos_next = POS_W'(i);
    end

    always_comb
    begin
        wide = '0;
        sh   = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (pos_reg > POS_W'(NRM_TOP))
            begin
                sh   = pos_reg - POS_W'(NRM_TOP);
                wide = 64'(mag4_reg[i]) >> sh;
            end
            else
            begin
                sh   = POS_W'(NRM_TOP) - pos_reg;
                wide = 64'(mag4_reg[i]) << sh;
            end
            nm_next[i] = wide[NRM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < 5; i++)
                side_reg[i] <= side_reg[i-1];
            mx_reg   <= mx_next;
            mag3_reg <= mag;
            mag4_reg <= mag3_reg;
            pos_reg  <= pos_next;
            nm5_reg  <= nm_next;
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= nm5_reg[i] * nm5_reg[i];
            nm6_reg  <= nm5_reg;
            sum_reg  <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1])
                      + SQ_W'(sq_reg[2]) + SQ_W'(sq_reg[3]);
            nm7_reg  <= nm6_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign nsum      = sum_reg;
    assign nmag      = nm7_reg;
    assign side_out  = side_reg[4];

endmodule

>>> rtl/core/rmq_sqrt.sv
// ---------------------------------------------------------------------------
// rmq_sqrt: pipelined integer square root
// One root bit per stage, floor of the square root of the sum of squares.
// ---------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [SQ_W-1:0]             nsum,
    input  logic [3:0][NRM_W-1:0]       nmag_in,
    input  side_t                       side_in,
    output logic                        out_valid,
    output logic [ROOT_W-1:0]           root,
    output logic [3:0][NRM_W-1:0]       nmag_out,
    output side_t                       side_out
);

    logic [ROOT_W-1:0]         v_reg;
    logic [SQ_W:0]             rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]         root_reg [ROOT_W];
    logic [3:0][NRM_W-1:0]     nm_reg   [ROOT_W];
    side_t                     side_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        localparam int K = ROOT_W - 1 - j;
        logic [SQ_W:0]         rem_prev, trial;
        logic [ROOT_W-1:0]     root_prev;
        logic [3:0][NRM_W-1:0] nm_prev;
        side_t                 side_prev;
        logic                  v_prev;

        if (j == 0)
        begin : g_first
            assign rem_prev  = (SQ_W+1)'(nsum);
            assign root_prev = '0;
            assign nm_prev   = nmag_in;
            assign side_prev = side_in;
            assign v_prev    = in_valid;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign nm_prev   = nm_reg[j-1];
            assign side_prev = side_reg[j-1];
            assign v_prev    = v_reg[j-1];
        end

        // (root + 2^K)^2 - root^2 = root*2^(K+1) + 4^K
        assign trial = ((SQ_W+1)'(root_prev) << (K + 1))
                     + ({{SQ_W{1'b0}}, 1'b1} << (2 * K));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_prev >= trial)
                begin
                    rem_reg[j]  <= rem_prev - trial;
                    root_reg[j] <= root_prev | (ROOT_W'(1) << K);
                end
                else
                begin
                    rem_reg[j]  <= rem_prev;
                    root_reg[j] <= root_prev;
                end
                nm_reg[j]   <= nm_prev;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign nmag_out  = nm_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

>>> rtl/core/rmq_div.sv
// ---------------------------------------------------------------------------
// rmq_div: four-lane pipelined rounding divider
// Forms magnitude * 2^FRAC_BITS + root/2 and divides by the root, one bit a stage.
// ---------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ROOT_W-1:0]           root,
    input  logic [3:0][NRM_W-1:0]       nmag,
    input  side_t                       side_in,
    output logic                        out_valid,
    output logic [3:0][FRAC_BITS:0]     quo,
    output side_t                       side_out
);

    localparam int NUM_W = NRM_W + FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int NST   = QW;

    logic [ROOT_W-1:0]        den;
    logic [3:0][NUM_W-1:0]    num_next, num_reg;
    logic [ROOT_W-1:0]        den_reg;
    side_t                    side0_reg;
    logic                     v0_reg;

    logic [NST-1:0]           v_reg;
    logic [3:0][NUM_W-1:0]    rem_reg  [NST];
    logic [3:0][QW-1:0]       q_reg    [NST];
    logic [ROOT_W-1:0]        dd_reg   [NST];
    side_t                    side_reg [NST];

    // A zero root only arises for an invalid word, whose result is replaced.
    assign den = (root == '0) ? ROOT_W'(1) : root;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            num_next[i] = (NUM_W'(nmag[i]) << FRAC_BITS) + NUM_W'(den >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg   <= num_next;
            den_reg   <= den;
            side0_reg <= side_in;
        end
    end

    for (genvar j = 0; j < NST; j++)
    begin : g_stage
        localparam int K = NST - 1 - j;
        logic [3:0][NUM_W-1:0] rem_prev;
        logic [3:0][QW-1:0]    q_prev;
        logic [ROOT_W-1:0]     dd_prev;
        side_t                 side_prev;
        logic                  v_prev;
        logic [NUM_W-1:0]      dsh;

        if (j == 0)
        begin : g_first
            assign rem_prev  = num_reg;
            assign q_prev    = '0;
            assign dd_prev   = den_reg;
            assign side_prev = side0_reg;
            assign v_prev    = v0_reg;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[j-1];
            assign q_prev    = q_reg[j-1];
            assign dd_prev   = dd_reg[j-1];
            assign side_prev = side_reg[j-1];
            assign v_prev    = v_reg[j-1];
        end

        assign dsh = NUM_W'(dd_prev) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (rem_prev[i] >= dsh)
                    begin
                        rem_reg[j][i] <= rem_prev[i] - dsh;
                        q_reg[j][i]   <= q_prev[i] | (QW'(1) << K);
                    end
                    else
                    begin
                        rem_reg[j][i] <= rem_prev[i];
                        q_reg[j][i]   <= q_prev[i];
                    end
                end
                dd_reg[j]   <= dd_prev;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign quo       = q_reg[NST-1];
    assign side_out  = side_reg[NST-1];

endmodule

>>> rtl/core/rotation_matrix_to_quaternion_top.sv
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top: rotation matrix to unit conjugate quaternion
// Shepperd branch selection, block normalisation, square root and division.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         tdata: ax_x..az_z, nine signed words of 16 bits
// m_axis    out        tdata: quat_w..quat_z, four signed 16 bit words;
//                      tuser: invalid
//
// One word may enter in every cycle while the pipeline is not holding still. The
// pipeline is made of the two front stages, the normalisation stages, one root
// bit per square root stage, the numerator stage, one quotient bit per divider
// stage and the output register. Reset clears only the valid bits.
// The whole pipeline advances together; it holds still only while the output
// register is full and the sink is not ready, so no word is lost or repeated.
//
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // ax_x, ax_y, ax_z, ay_x, ay_y, ay_z, az_x, az_y, az_z from bit 0 upwards
    input  logic [143:0]        s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 upwards
    output logic [63:0]         m_axis_tdata,
    // invalid
    output logic                m_axis_tuser
);

    // Radicands reach ONE plus three full entries, with a sign bit on top.
    localparam int RAD_W = ((FRAC_BITS > IN_W + 1) ? FRAC_BITS : IN_W + 1) + 3;
    // The signed result must hold both the quotient with its sign and the output range.
    localparam int SV_W  = (FRAC_BITS + 3 > OUT_W + 1) ? FRAC_BITS + 3 : OUT_W + 1;
    localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic                      en;
    mat_t                      mat;

    logic                      f_valid;
    logic [3:0][RAD_W-1:0]     f_mag;
    side_t                     f_side;

    logic                      n_valid;
    logic [SQ_W-1:0]           n_sum;
    logic [3:0][NRM_W-1:0]     n_mag;
    side_t                     n_side;

    logic                      r_valid;
    logic [ROOT_W-1:0]         r_root;
    logic [3:0][NRM_W-1:0]     r_mag;
    side_t                     r_side;

    logic                      d_valid;
    logic [3:0][FRAC_BITS:0]   d_quo;
    side_t                     d_side;

    logic signed [SV_W-1:0]    sv;
    logic [3:0][OUT_W-1:0]     quat_next, quat_reg;
    logic                      out_valid_reg;
    logic                      invalid_reg;

    // Every stage moves when the output register is empty or being drained.
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign mat           = mat_t'(s_axis_tdata);

    rmq_front #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .mat       (mat),
        .out_valid (f_valid),
        .mag       (f_mag),
        .side      (f_side)
    );

    rmq_norm #(
        .MAG_W     (RAD_W)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .mag       (f_mag),
        .side_in   (f_side),
        .out_valid (n_valid),
        .nsum      (n_sum),
        .nmag      (n_mag),
        .side_out  (n_side)
    );

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_valid),
        .nsum      (n_sum),
        .nmag_in   (n_mag),
        .side_in   (n_side),
        .out_valid (r_valid),
        .root      (r_root),
        .nmag_out  (r_mag),
        .side_out  (r_side)
    );

    rmq_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .root      (r_root),
        .nmag      (r_mag),
        .side_in   (r_side),
        .out_valid (d_valid),
        .quo       (d_quo),
        .side_out  (d_side)
    );

    // Sign restoration, conjugation of the vector part, saturation to 16 bits.
    // An invalid word gives the identity quaternion instead.
    always_comb
    begin
        sv = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (d_side.invalid)
                sv = (i == 0) ? (SV_W'(1) << FRAC_BITS) : '0;
            else if (d_side.neg[i] ^ (i != 0))
                sv = -(signed'(SV_W'(d_quo[i])));
            else
                sv = signed'(SV_W'(d_quo[i]));

            if (sv > SV_W'(SAT_MAX))
                quat_next[i] = SAT_MAX;
            else if (sv < SV_W'(SAT_MIN))
                quat_next[i] = SAT_MIN;
            else
                quat_next[i] = sv[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_reg    <= quat_next;
            invalid_reg <= d_side.invalid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = quat_reg;
    assign m_axis_tuser  = invalid_reg;

endmodule
